// ===== hw/rtl/rpnc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpnc_pkg: shared constants for the rpn stack calculator
// data width, operator and status codes, token kinds
// ----------------------------------------------------------------------------
package rpnc_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int DEPTH_W         = 5;
  localparam int STATUS_W        = 2;
  localparam int OP_W            = 2;
  localparam int ITER_W          = $clog2(DATA_W);

  // token kinds
  localparam logic KIND_NUM = 1'b0;
  localparam logic KIND_OP  = 1'b1;

  // operator codes
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  // sticky status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 2'd3;

endpackage

// ===== hw/rtl/rpnc_ram.sv =====
// ----------------------------------------------------------------------------
// rpnc_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rpnc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rpn_stack_calculator_core.sv =====
// ----------------------------------------------------------------------------
// rpn_stack_calculator_core: postfix integer expression evaluator
// sequence: a push runs decode then finish; add/sub run decode, load, finish;
//   multiply runs the 32-step shift-add loop and divide the 32-step
//   restoring-divide loop (with abs and sign steps), both on the shared 33-bit adder
// throughput: one token at a time; in_ready is high only while the sequencer
//   idles, so the next token is taken only after the result is registered
// reset: synchronous active-high rst empties the stack, clears status and out_valid
// ----------------------------------------------------------------------------
module rpn_stack_calculator_core
  import rpnc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  // token beat
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic signed [DATA_W-1:0]   number,
  input  logic [OP_W-1:0]            op_code,
  input  logic                       last,
  // result beat
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DATA_W-1:0]   top_value,
  output logic [STATUS_W-1:0]        status,
  output logic [DEPTH_W-1:0]         depth,
  output logic                       done_res
);

  // stack pointer holds 0..STACK_DEPTH, ram address covers the entries
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int AW   = $clog2(STACK_DEPTH);

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_ABS_A  = 4'd3;
  localparam logic [3:0] S_ABS_B  = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_SIGN   = 4'd7;
  localparam logic [3:0] S_FINISH = 4'd8;

  logic [3:0]          state;
  logic [SP_W-1:0]     sp;
  logic [STATUS_W-1:0] sticky;

  // top of stack lives in a register; the ram holds the entries below it,
  // so an operator needs only one ram read (the left operand)
  logic [DATA_W-1:0]   top;

  // latched token
  logic                tok_kind;
  logic [DATA_W-1:0]   tok_number;
  logic [OP_W-1:0]     tok_op;
  logic                tok_last;

  // shared unit working registers
  logic [DATA_W-1:0]   opa;     // left operand / multiplicand / dividend-quotient
  logic [DATA_W-1:0]   opb;     // right operand / multiplier / divisor
  logic [DATA_W-1:0]   acc;     // product or partial remainder
  logic [ITER_W-1:0]   cnt;
  logic                div_neg;

  // shared adder / subtractor, one extra bit for carry or borrow
  logic [DATA_W-1:0]   alu_a;
  logic [DATA_W-1:0]   alu_b;
  logic                alu_sub;
  logic [DATA_W:0]     alu_bx;
  logic [DATA_W:0]     alu_sum;

  logic [SP_W-1:0]     sp_m1;
  logic [SP_W-1:0]     sp_m2;
  logic                ram_we;
  logic [DATA_W-1:0]   ram_rdata;
  logic                out_free;
  logic                clear_now;
  logic                div_bit;

  assign sp_m1     = sp - SP_W'(1);
  assign sp_m2     = sp - SP_W'(2);
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;
  assign clear_now = (state == S_FINISH) && out_free && tok_last;

  // push spills the old top into the ram unless the stack was empty or full
  assign ram_we = (state == S_DECODE) && (tok_kind == KIND_NUM) &&
                  (sp < SP_W'(STACK_DEPTH)) && (sp != '0);

  rpnc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_m1[AW-1:0]),
    .wdata (top),
    .raddr (sp_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  // operand selection for the shared unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_LOAD: begin
        alu_a   = ram_rdata;
        alu_b   = top;
        alu_sub = (tok_op == OP_SUB);
      end
      S_ABS_A: begin
        alu_b   = opa;
        alu_sub = 1'b1;
      end
      S_ABS_B: begin
        alu_b   = opb;
        alu_sub = 1'b1;
      end
      S_MUL: begin
        alu_a = acc;
        alu_b = opb[0] ? opa : '0;
      end
      S_DIV: begin
        // shift next dividend bit into the partial remainder, trial subtract
        alu_a   = {acc[DATA_W-2:0], opa[DATA_W-1]};
        alu_b   = opb;
        alu_sub = 1'b1;
      end
      S_SIGN: begin
        alu_b   = opa;
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign alu_bx  = alu_sub ? ~{1'b0, alu_b} : {1'b0, alu_b};
  assign alu_sum = {1'b0, alu_a} + alu_bx + {{DATA_W{1'b0}}, alu_sub};
  // no borrow means the trial subtract fits: quotient bit is one
  assign div_bit = !alu_sum[DATA_W];

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      sticky    <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // the finish step reloads the output register itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tok_kind   <= kind;
            tok_number <= number;
            tok_op     <= op_code;
            tok_last   <= last;
            state      <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (tok_kind == KIND_NUM) begin
            if (sp < SP_W'(STACK_DEPTH)) begin
              top <= tok_number;
              sp  <= sp + SP_W'(1);
            end else if (sticky == ST_OK) begin
              sticky <= ST_OVER;
            end
            state <= S_FINISH;
          end else if (sp >= SP_W'(2)) begin
            // left operand read issued at sp-2, data next cycle
            state <= S_LOAD;
          end else begin
            if (sticky == ST_OK) begin
              sticky <= ST_UNDER;
            end
            state <= S_FINISH;
          end
        end
        S_LOAD: begin
          opa     <= ram_rdata;
          opb     <= top;
          acc     <= '0;
          cnt     <= '0;
          div_neg <= ram_rdata[DATA_W-1] ^ top[DATA_W-1];
          case (tok_op) inside
            OP_ADD, OP_SUB: begin
              top   <= alu_sum[DATA_W-1:0];
              sp    <= sp_m1;
              state <= S_FINISH;
            end
            OP_MUL: begin
              state <= S_MUL;
            end
            default: begin
              if (top == '0) begin
                // divide by zero pops both and pushes zero
                if (sticky == ST_OK) begin
                  sticky <= ST_DIVZ;
                end
                top   <= '0;
                sp    <= sp_m1;
                state <= S_FINISH;
              end else begin
                state <= S_ABS_A;
              end
            end
          endcase
        end
        S_ABS_A: begin
          if (opa[DATA_W-1]) begin
            opa <= alu_sum[DATA_W-1:0];
          end
          state <= S_ABS_B;
        end
        S_ABS_B: begin
          if (opb[DATA_W-1]) begin
            opb <= alu_sum[DATA_W-1:0];
          end
          state <= S_DIV;
        end
        S_MUL: begin
          acc <= alu_sum[DATA_W-1:0];
          opa <= {opa[DATA_W-2:0], 1'b0};
          opb <= {1'b0, opb[DATA_W-1:1]};
          cnt <= cnt + ITER_W'(1);
          if (cnt == ITER_W'(DATA_W - 1)) begin
            top   <= alu_sum[DATA_W-1:0];
            sp    <= sp_m1;
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          if (div_bit) begin
            acc <= alu_sum[DATA_W-1:0];
          end else begin
            acc <= alu_a;
          end
          opa <= {opa[DATA_W-2:0], div_bit};
          cnt <= cnt + ITER_W'(1);
          if (cnt == ITER_W'(DATA_W - 1)) begin
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          top   <= div_neg ? alu_sum[DATA_W-1:0] : opa;
          sp    <= sp_m1;
          state <= S_FINISH;
        end
        S_FINISH: begin
          // wait for the output register to free up
          if (out_free) begin
            out_valid <= 1'b1;
            top_value <= (sp != '0) ? top : '0;
            status    <= sticky;
            depth     <= DEPTH_W'(sp);
            done_res  <= tok_last;
            if (tok_last) begin
              sp     <= '0;
              sticky <= ST_OK;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // stack pointer never passes the stack size
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // status keeps its first error until the expression ends
  a_sticky_hold: assert property (@(posedge clk) disable iff (rst)
    (sticky != ST_OK) && !clear_now |=> sticky == $past(sticky))
    else $error("sticky status changed");

  // stack moves by at most one entry per token step unless cleared
  a_sp_step: assert property (@(posedge clk) disable iff (rst)
    !clear_now |=> (sp == $past(sp)) || (sp == $past(sp) + SP_W'(1)) ||
                   (sp == $past(sp) - SP_W'(1)))
    else $error("stack pointer jumped");

  // a result beat only appears when leaving the finish step
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result beat without finished token");
`endif

endmodule
